// File: hdl/dmrk_pkg.sv
// ----------------------------------------------------------------------------
// dmrk_pkg
// Shared types, constants and saturating helpers of the density matrix
// Runge-Kutta stepper.
// ----------------------------------------------------------------------------
`default_nettype none

package dmrk_pkg;

   localparam int FRAC_BITS  = 24;
   localparam int CSR_ADDR_W = 3;

   localparam logic signed [31:0] Q_ONE     = 32'sd1 <<< FRAC_BITS;
   localparam logic signed [31:0] Q_MAX     = 32'sh7fff_ffff;
   localparam logic signed [31:0] Q_MIN     = 32'sh8000_0000;
   localparam logic signed [63:0] MUL_ROUND = 64'sd1 <<< (FRAC_BITS - 1);
   localparam logic [30:0]        STEP_RESET = 31'd1 << FRAC_BITS;

   // ceil(2^33 / 3): x * RECIP_THIRD >> 33 is floor(x / 3) for any 32-bit x
   localparam logic [31:0] RECIP_THIRD = 32'haaaa_aaab;

   // register indexes (byte address bit 2)
   localparam logic REG_STEP_SIZE = 1'b0;

   // sequencer steps within one stage
   localparam logic [4:0] STEP_FIRST_D = 5'd9;
   localparam logic [4:0] STEP_UPD     = 5'd10;
   localparam logic [4:0] STEP_LAST    = 5'd26;
   localparam logic [1:0] STAGE_LAST   = 2'd3;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_DIV    = 4'b0010,
      ST_STAGE  = 4'b0100,
      ST_FINISH = 4'b1000
   } dmrk_state_type;

   typedef struct packed {
      logic start;
      logic load_lower;
      logic slot_free;
   } dmrk_ctl_type;

   typedef struct packed {
      logic idle;
      logic done;
   } dmrk_stat_type;

   typedef logic signed [31:0] dmrk_q_type;

   function automatic dmrk_q_type sat33(input logic signed [32:0] s);
      dmrk_q_type r;
      if (s[32] != s[31]) begin
         r = s[32] ? Q_MIN : Q_MAX;
      end else begin
         r = s[31:0];
      end
      return r;
   endfunction

   function automatic dmrk_q_type sat_add(input dmrk_q_type a, input dmrk_q_type b);
      logic signed [32:0] s;
      s = {a[31], a} + {b[31], b};
      return sat33(s);
   endfunction

   function automatic dmrk_q_type sat_sub(input dmrk_q_type a, input dmrk_q_type b);
      logic signed [32:0] s;
      s = {a[31], a} - {b[31], b};
      return sat33(s);
   endfunction

endpackage

`default_nettype wire

// File: hdl/dmrk_if.sv
// ----------------------------------------------------------------------------
// dmrk_req_if / dmrk_rsp_if
// Valid/ready channels of the stepper: step request and matrix result.
// ----------------------------------------------------------------------------
`default_nettype none

interface dmrk_req_if;
   logic               valid;
   logic               ready;
   logic               command;
   logic signed [31:0] velocity;
   logic signed [31:0] coupling_now;
   logic signed [31:0] coupling_next;
   logic signed [31:0] lower_energy_now;
   logic signed [31:0] lower_energy_next;
   logic signed [31:0] upper_energy_now;
   logic signed [31:0] upper_energy_next;

   modport source (output valid, command, velocity, coupling_now, coupling_next,
                   lower_energy_now, lower_energy_next, upper_energy_now,
                   upper_energy_next, input ready);
   modport sink (input valid, command, velocity, coupling_now, coupling_next,
                 lower_energy_now, lower_energy_next, upper_energy_now,
                 upper_energy_next, output ready);
endinterface

interface dmrk_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] pop_lower_re;
   logic signed [31:0] pop_lower_im;
   logic signed [31:0] coher_up_re;
   logic signed [31:0] coher_up_im;
   logic signed [31:0] coher_down_re;
   logic signed [31:0] coher_down_im;
   logic signed [31:0] pop_upper_re;
   logic signed [31:0] pop_upper_im;

   modport source (output valid, pop_lower_re, pop_lower_im, coher_up_re, coher_up_im,
                   coher_down_re, coher_down_im, pop_upper_re, pop_upper_im,
                   input ready);
   modport sink (input valid, pop_lower_re, pop_lower_im, coher_up_re, coher_up_im,
                 coher_down_re, coher_down_im, pop_upper_re, pop_upper_im,
                 output ready);
endinterface

`default_nettype wire

// File: hdl/density_matrix_rk4_step.sv
// ----------------------------------------------------------------------------
// density_matrix_rk4_step
// Two-level density matrix stepper, one fourth-order Runge-Kutta step per beat.
// ----------------------------------------------------------------------------
// An integrate beat is captured on acceptance; the h/3 and h/6 weights of the
// step size are then formed by reciprocal multiplication, then four stages run
// on the single shared Q8.24 multiplier (the nine derivative products, then the
// accumulate and probe updates, then a drain step), and the result is handed
// off once the output register is free. A reset beat (command 1) loads the
// lower state and is handed off the same way. req.ready is high only while
// the sequencer is idle; a finished result waits in the output register, so
// the next beat can be accepted while it is still held. step_size sits at
// byte address 0 and may be written only while the block is idle.
`default_nettype none

module density_matrix_rk4_step
   import dmrk_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   dmrk_req_if.sink              req,
   dmrk_rsp_if.source            rsp,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   logic [30:0]      step_ff, step_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0][31:0] rsp_data_ff, rsp_data_in;
   logic [7:0][31:0] rho;
   dmrk_ctl_type     ctl;
   dmrk_stat_type    stat;

   assign pready = 1'b1;
   assign prdata = (paddr[2] == REG_STEP_SIZE) ? {1'b0, step_ff} : '0;

   always_comb begin
      step_in = step_ff;
      if (psel && penable && pwrite && paddr[2] == REG_STEP_SIZE) begin
         step_in = pwdata[30:0];
      end
   end

   assign req.ready      = stat.idle;
   assign ctl.start      = req.valid && stat.idle;
   assign ctl.load_lower = req.command;
   assign ctl.slot_free  = !rsp_valid_ff || rsp.ready;

   dmrk_core u_core (
      .clock             (clock),
      .reset             (reset),
      .ctl               (ctl),
      .velocity          (req.velocity),
      .coupling_now      (req.coupling_now),
      .coupling_next     (req.coupling_next),
      .lower_energy_now  (req.lower_energy_now),
      .lower_energy_next (req.lower_energy_next),
      .upper_energy_now  (req.upper_energy_now),
      .upper_energy_next (req.upper_energy_next),
      .step_size         (step_ff),
      .stat              (stat),
      .rho               (rho)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (stat.done) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = rho;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         step_ff      <= STEP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.pop_lower_re  = rsp_data_ff[0];
   assign rsp.pop_lower_im  = rsp_data_ff[1];
   assign rsp.coher_up_re   = rsp_data_ff[2];
   assign rsp.coher_up_im   = rsp_data_ff[3];
   assign rsp.coher_down_re = rsp_data_ff[4];
   assign rsp.coher_down_im = rsp_data_ff[5];
   assign rsp.pop_upper_re  = rsp_data_ff[6];
   assign rsp.pop_upper_im  = rsp_data_ff[7];

endmodule

`default_nettype wire

// File: hdl/dmrk_mulq.sv
// ----------------------------------------------------------------------------
// dmrk_mulq
// Shared fixed point multiplier: round half up, saturate, registered result.
// ----------------------------------------------------------------------------
`default_nettype none

module dmrk_mulq
   import dmrk_pkg::*;
(
   input  logic       clock,
   input  dmrk_q_type op_a,
   input  dmrk_q_type op_b,
   output dmrk_q_type prod_ff
);

   logic signed [63:0] full;
   logic signed [63:0] rnd;
   logic signed [63:0] shr;
   dmrk_q_type         prod_in;

   always_comb begin
      full = 64'(op_a) * 64'(op_b);
      rnd  = full + MUL_ROUND;
      shr  = rnd >>> FRAC_BITS;
      if (shr > 64'(Q_MAX)) begin
         prod_in = Q_MAX;
      end else if (shr < 64'(Q_MIN)) begin
         prod_in = Q_MIN;
      end else begin
         prod_in = shr[31:0];
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

`default_nettype wire

// File: hdl/dmrk_wdiv.sv
// ----------------------------------------------------------------------------
// dmrk_wdiv
// Stage weights (h+1)/3 and (h+3)/6 by reciprocal multiplication, one
// product per cycle on a single 32x32 multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module dmrk_wdiv
   import dmrk_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [30:0] step_size,
   output logic [31:0] third,
   output logic [31:0] sixth,
   output logic        fin_ff
);

   logic [31:0] num_ff, num_in, nsix_ff, nsix_in;
   logic [31:0] third_ff, third_in, sixth_ff, sixth_in;
   logic [1:0]  phase_ff, phase_in;
   logic        fin_in;
   logic [63:0] prod;
   logic [31:0] quot;

   always_comb begin
      prod     = 64'(num_ff) * 64'(RECIP_THIRD);
      quot     = {1'b0, prod[63:33]};
      num_in   = num_ff;
      nsix_in  = nsix_ff;
      third_in = third_ff;
      sixth_in = sixth_ff;
      phase_in = phase_ff;
      fin_in   = 1'b0;
      if (start) begin
         num_in   = {1'b0, step_size} + 32'd1;
         // floor(x/6) is floor(floor(x/2)/3)
         nsix_in  = ({1'b0, step_size} + 32'd3) >> 1;
         phase_in = 2'b01;
      end else if (phase_ff[0]) begin
         third_in = quot;
         num_in   = nsix_ff;
         phase_in = 2'b10;
      end else if (phase_ff[1]) begin
         sixth_in = quot;
         phase_in = 2'b00;
         fin_in   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      num_ff   <= num_in;
      nsix_ff  <= nsix_in;
      third_ff <= third_in;
      sixth_ff <= sixth_in;
      if (reset) begin
         phase_ff <= '0;
         fin_ff   <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         fin_ff   <= fin_in;
      end
   end

   assign third = third_ff;
   assign sixth = sixth_ff;

endmodule

`default_nettype wire

// File: hdl/dmrk_core.sv
// ----------------------------------------------------------------------------
// dmrk_core
// Sequencer and register file: four Runge-Kutta stages on one shared multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module dmrk_core
   import dmrk_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  dmrk_ctl_type      ctl,
   input  dmrk_q_type        velocity,
   input  dmrk_q_type        coupling_now,
   input  dmrk_q_type        coupling_next,
   input  dmrk_q_type        lower_energy_now,
   input  dmrk_q_type        lower_energy_next,
   input  dmrk_q_type        upper_energy_now,
   input  dmrk_q_type        upper_energy_next,
   input  logic [30:0]       step_size,
   output dmrk_stat_type     stat,
   output logic [7:0][31:0]  rho
);

   // entry order: 00 re, 00 im, 01 re, 01 im, 10 re, 10 im, 11 re, 11 im
   dmrk_state_type state_ff, state_in;
   logic [1:0]     stage_ff, stage_in;
   logic [4:0]     step_ff, step_in;

   dmrk_q_type v_ff, v_in, g0_ff, g0_in, g1_ff, g1_in;
   dmrk_q_type l0_ff, l0_in, l1_ff, l1_in, u0_ff, u0_in, u1_ff, u1_in;
   dmrk_q_type wt3_ff, wt3_in, wt6_ff, wt6_in;
   dmrk_q_type sr_ff, sr_in, si_ff, si_in, fr_ff, fr_in, fi_ff, fi_in, de_ff, de_in;
   dmrk_q_type vg_ff, vg_in, pr_ff, pr_in, pi_ff, pi_in, qr_ff, qr_in, qi_ff, qi_in;
   dmrk_q_type r_ff [8];
   dmrk_q_type r_in [8];
   dmrk_q_type y_ff [8];
   dmrk_q_type y_in [8];
   dmrk_q_type a_ff [8];
   dmrk_q_type a_in [8];
   dmrk_q_type d_ff [8];
   dmrk_q_type d_in [8];

   dmrk_q_type         mul_a, mul_b, mul_p;
   dmrk_q_type         sg, sl, su, adv, wt;
   logic signed [32:0] gs, ls, us;
   logic [3:0]         oi, oc;
   logic               div_start, div_fin;
   logic [31:0]        div_third, div_sixth;

   dmrk_mulq u_mulq (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .prod_ff (mul_p)
   );

   dmrk_wdiv u_wdiv (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .step_size (step_size),
      .third     (div_third),
      .sixth     (div_sixth),
      .fin_ff    (div_fin)
   );

   assign div_start = ctl.start && !ctl.load_lower;

   // per-stage coupling and energies
   always_comb begin
      gs = {g0_ff[31], g0_ff} + {g1_ff[31], g1_ff};
      ls = {l0_ff[31], l0_ff} + {l1_ff[31], l1_ff};
      us = {u0_ff[31], u0_ff} + {u1_ff[31], u1_ff};
      if (stage_ff == 2'd0) begin
         sg = g0_ff;
         sl = l0_ff;
         su = u0_ff;
      end else if (stage_ff == STAGE_LAST) begin
         sg = g1_ff;
         sl = l1_ff;
         su = u1_ff;
      end else begin
         sg = gs[32:1];
         sl = ls[32:1];
         su = us[32:1];
      end
      adv = (stage_ff < 2'd2) ? {2'b0, step_size[30:1]} : {1'b0, step_size};
      wt  = (stage_ff == 2'd0 || stage_ff == STAGE_LAST) ? wt6_ff : wt3_ff;
      oi  = 4'(step_ff - STEP_UPD);
      oc  = 4'(step_ff - STEP_UPD - 5'd1);
   end

   // multiplier operands
   always_comb begin
      mul_a = v_ff;
      mul_b = sg;
      case (step_ff)
         5'd1: begin
            mul_a = mul_p;
            mul_b = sr_ff;
         end
         5'd2: begin
            mul_a = vg_ff;
            mul_b = si_ff;
         end
         5'd3: begin
            mul_a = vg_ff;
            mul_b = fr_ff;
         end
         5'd4: begin
            mul_a = vg_ff;
            mul_b = fi_ff;
         end
         5'd5: begin
            mul_a = y_ff[3];
            mul_b = de_ff;
         end
         5'd6: begin
            mul_a = y_ff[2];
            mul_b = de_ff;
         end
         5'd7: begin
            mul_a = y_ff[5];
            mul_b = de_ff;
         end
         5'd8: begin
            mul_a = y_ff[4];
            mul_b = de_ff;
         end
         default: begin
            if (step_ff >= STEP_UPD) begin
               mul_a = oi[0] ? adv : wt;
               mul_b = d_ff[oi[3:1]];
            end
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      stage_in = stage_ff;
      step_in  = step_ff;
      v_in  = v_ff;
      g0_in = g0_ff;
      g1_in = g1_ff;
      l0_in = l0_ff;
      l1_in = l1_ff;
      u0_in = u0_ff;
      u1_in = u1_ff;
      wt3_in = wt3_ff;
      wt6_in = wt6_ff;
      sr_in = sr_ff;
      si_in = si_ff;
      fr_in = fr_ff;
      fi_in = fi_ff;
      de_in = de_ff;
      vg_in = vg_ff;
      pr_in = pr_ff;
      pi_in = pi_ff;
      qr_in = qr_ff;
      qi_in = qi_ff;
      r_in = r_ff;
      y_in = y_ff;
      a_in = a_ff;
      d_in = d_ff;
      stat.idle = (state_ff == ST_IDLE);
      stat.done = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (ctl.start) begin
               if (ctl.load_lower) begin
                  for (int k = 0; k < 8; k++) begin
                     r_in[k] = '0;
                  end
                  r_in[0]  = Q_ONE;
                  state_in = ST_FINISH;
               end else begin
                  v_in  = velocity;
                  g0_in = coupling_now;
                  g1_in = coupling_next;
                  l0_in = lower_energy_now;
                  l1_in = lower_energy_next;
                  u0_in = upper_energy_now;
                  u1_in = upper_energy_next;
                  y_in  = r_ff;
                  a_in  = r_ff;
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            if (div_fin) begin
               wt3_in   = div_third;
               wt6_in   = div_sixth;
               stage_in = '0;
               step_in  = '0;
               state_in = ST_STAGE;
            end
         end
         ST_STAGE: begin
            step_in = step_ff + 5'd1;
            case (step_ff)
               5'd0: begin
                  sr_in = sat_add(y_ff[2], y_ff[4]);
                  si_in = sat_add(y_ff[3], y_ff[5]);
                  fr_in = sat_sub(y_ff[0], y_ff[6]);
                  fi_in = sat_sub(y_ff[1], y_ff[7]);
                  de_in = sat_sub(sl, su);
               end
               5'd1: vg_in = mul_p;
               5'd2: pr_in = mul_p;
               5'd3: pi_in = mul_p;
               5'd4: qr_in = mul_p;
               5'd5: qi_in = mul_p;
               5'd6: d_in[2] = sat_add(qr_ff, mul_p);
               5'd7: d_in[3] = sat_sub(qi_ff, mul_p);
               5'd8: d_in[4] = sat_sub(qr_ff, mul_p);
               STEP_FIRST_D: begin
                  d_in[5] = sat_add(qi_ff, mul_p);
                  d_in[0] = sat_sub('0, pr_ff);
                  d_in[1] = sat_sub('0, pi_ff);
                  d_in[6] = pr_ff;
                  d_in[7] = pi_ff;
               end
               default: begin
                  // even beats accumulate the weighted slope, odd ones form the probe point
                  if (step_ff > STEP_UPD) begin
                     if (!oc[0]) begin
                        a_in[oc[3:1]] = sat_add(a_ff[oc[3:1]], mul_p);
                     end else begin
                        y_in[oc[3:1]] = sat_add(r_ff[oc[3:1]], mul_p);
                     end
                  end
                  if (step_ff == STEP_LAST) begin
                     step_in = '0;
                     if (stage_ff == STAGE_LAST) begin
                        r_in     = a_ff;
                        state_in = ST_FINISH;
                     end else begin
                        stage_in = stage_ff + 2'd1;
                     end
                  end
               end
            endcase
         end
         ST_FINISH: begin
            if (ctl.slot_free) begin
               stat.done = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      for (int k = 0; k < 8; k++) begin
         rho[k] = r_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      v_ff  <= v_in;
      g0_ff <= g0_in;
      g1_ff <= g1_in;
      l0_ff <= l0_in;
      l1_ff <= l1_in;
      u0_ff <= u0_in;
      u1_ff <= u1_in;
      wt3_ff <= wt3_in;
      wt6_ff <= wt6_in;
      sr_ff <= sr_in;
      si_ff <= si_in;
      fr_ff <= fr_in;
      fi_ff <= fi_in;
      de_ff <= de_in;
      vg_ff <= vg_in;
      pr_ff <= pr_in;
      pi_ff <= pi_in;
      qr_ff <= qr_in;
      qi_ff <= qi_in;
      y_ff  <= y_in;
      a_ff  <= a_in;
      d_ff  <= d_in;
      if (reset) begin
         state_ff <= ST_IDLE;
         stage_ff <= '0;
         step_ff  <= '0;
         for (int k = 0; k < 8; k++) begin
            r_ff[k] <= (k == 0) ? Q_ONE : '0;
         end
      end else begin
         state_ff <= state_in;
         stage_ff <= stage_in;
         step_ff  <= step_in;
         r_ff     <= r_in;
      end
   end

endmodule

`default_nettype wire

// File: hdl/dmrk_checker.sv
// ----------------------------------------------------------------------------
// dmrk_checker
// Port-level checks of the stepper, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dmrk_checker
   import dmrk_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       req_command,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input dmrk_q_type pop_lower_re,
   input dmrk_q_type pop_lower_im,
   input dmrk_q_type coher_up_re,
   input dmrk_q_type pop_upper_re
);

   logic req_beat;
   assign req_beat = req_valid && req_ready;

   // a stalled result stays valid and its pop_lower_re field holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(pop_lower_re))
      else $error("result dropped or changed while stalled");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_busy_after_beat: assert property (@(posedge clock) disable iff (reset)
      req_beat |=> !req_ready)
      else $error("request taken while the sequencer is busy");

   a_lower_state: assert property (@(posedge clock) disable iff (reset)
      req_beat && req_command && !rsp_valid |=> ##1
         rsp_valid && pop_lower_re == Q_ONE && pop_lower_im == '0
         && coher_up_re == '0 && pop_upper_re == '0)
      else $error("reset beat did not load the lower state");

endmodule

bind density_matrix_rk4_step dmrk_checker u_dmrk_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req.valid),
   .req_ready    (req.ready),
   .req_command  (req.command),
   .rsp_valid    (rsp.valid),
   .rsp_ready    (rsp.ready),
   .pop_lower_re (rsp.pop_lower_re),
   .pop_lower_im (rsp.pop_lower_im),
   .coher_up_re  (rsp.coher_up_re),
   .pop_upper_re (rsp.pop_upper_re)
);

`default_nettype wire

// File: verif/tb_density_matrix_rk4_step.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_density_matrix_rk4_step
// Self-checking bench for the two-level density matrix Runge-Kutta stepper.
// A local fixed-point predictor follows every accepted step beat. Results
// are compared field by field in order. The run goes through several step
// sizes, written over the register port while the block is idle. Both
// channels idle and stall in random bursts, but for the last, quiet run.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_density_matrix_rk4_step
   import dmrk_pkg::*;
();

   typedef struct {
      logic               command;
      logic signed [31:0] velocity;
      logic signed [31:0] coupling_now;
      logic signed [31:0] coupling_next;
      logic signed [31:0] lower_now;
      logic signed [31:0] lower_next;
      logic signed [31:0] upper_now;
      logic signed [31:0] upper_next;
   } step_beat_type;

   typedef struct {
      logic signed [31:0] entry[8];
   } matrix_type;

   localparam longint LMAX = 64'sd2147483647;
   localparam longint LMIN = -64'sd2147483648;

   logic clock;
   logic reset;
   logic psel, penable, pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [31:0] pwdata, prdata;
   logic pready;

   dmrk_req_if req ();
   dmrk_rsp_if rsp ();

   density_matrix_rk4_step DUT (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   step_beat_type pending_beats[$];
   matrix_type    expected_matrices[$];
   longint        rho_re[4];
   longint        rho_im[4];
   longint        step_h;
   bit            quiet;
   int            mismatches;
   int            matrices_checked;
   int            resets_sent;
   int            send_burst;
   int            take_burst;

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   // ---------------- predictor ----------------
   function automatic longint sat(input longint x);
      if (x > LMAX) return LMAX;
      if (x < LMIN) return LMIN;
      return x;
   endfunction

   function automatic longint qmul(input longint a, input longint b);
      longint p;
      p = a * b + (64'sd1 <<< (FRAC_BITS - 1));
      return sat(p >>> FRAC_BITS);
   endfunction

   function automatic void slope(input longint v, input longint g, input longint el,
                                 input longint eu, input longint yr[4],
                                 input longint yi[4], output longint dr[4],
                                 output longint di[4]);
      longint vg, sr, si, fr, fi, de, pr, pi, qr, qi;
      vg = qmul(v, g);
      sr = sat(yr[1] + yr[2]);
      si = sat(yi[1] + yi[2]);
      fr = sat(yr[0] - yr[3]);
      fi = sat(yi[0] - yi[3]);
      de = sat(el - eu);
      pr = qmul(vg, sr);
      pi = qmul(vg, si);
      qr = qmul(vg, fr);
      qi = qmul(vg, fi);
      dr[0] = sat(-pr);
      di[0] = sat(-pi);
      dr[3] = pr;
      di[3] = pi;
      dr[1] = sat(qr + qmul(yi[1], de));
      di[1] = sat(qi - qmul(yr[1], de));
      dr[2] = sat(qr - qmul(yi[2], de));
      di[2] = sat(qi + qmul(yr[2], de));
   endfunction

   function automatic void load_lower_state();
      for (int k = 0; k < 4; k++) begin
         rho_re[k] = 0;
         rho_im[k] = 0;
      end
      rho_re[0] = longint'(Q_ONE);
   endfunction

   function automatic matrix_type advance_density(input step_beat_type b);
      matrix_type m;
      longint adv[3], wt[4], sg[4], sl[4], su[4];
      longint yr[4], yi[4], ar[4], ai[4], dr[4], di[4];
      if (b.command) begin
         load_lower_state();
      end else begin
         adv[0] = step_h >>> 1;
         adv[1] = adv[0];
         adv[2] = step_h;
         wt[0] = (step_h + 3) / 6;
         wt[1] = (step_h + 1) / 3;
         wt[2] = wt[1];
         wt[3] = wt[0];
         sg[0] = b.coupling_now;
         sl[0] = b.lower_now;
         su[0] = b.upper_now;
         sg[1] = (longint'(b.coupling_now) + longint'(b.coupling_next)) >>> 1;
         sl[1] = (longint'(b.lower_now) + longint'(b.lower_next)) >>> 1;
         su[1] = (longint'(b.upper_now) + longint'(b.upper_next)) >>> 1;
         sg[2] = sg[1];
         sl[2] = sl[1];
         su[2] = su[1];
         sg[3] = b.coupling_next;
         sl[3] = b.lower_next;
         su[3] = b.upper_next;
         for (int k = 0; k < 4; k++) begin
            yr[k] = rho_re[k];
            yi[k] = rho_im[k];
            ar[k] = rho_re[k];
            ai[k] = rho_im[k];
         end
         for (int s = 0; s < 4; s++) begin
            slope(longint'(b.velocity), sg[s], sl[s], su[s], yr, yi, dr, di);
            for (int k = 0; k < 4; k++) begin
               ar[k] = sat(ar[k] + qmul(wt[s], dr[k]));
               ai[k] = sat(ai[k] + qmul(wt[s], di[k]));
               if (s < 3) begin
                  yr[k] = sat(rho_re[k] + qmul(adv[s], dr[k]));
                  yi[k] = sat(rho_im[k] + qmul(adv[s], di[k]));
               end
            end
         end
         for (int k = 0; k < 4; k++) begin
            rho_re[k] = ar[k];
            rho_im[k] = ai[k];
         end
      end
      for (int k = 0; k < 4; k++) begin
         m.entry[2*k]   = rho_re[k][31:0];
         m.entry[2*k+1] = rho_im[k][31:0];
      end
      return m;
   endfunction

   // ---------------- step beat driver ----------------
   always @(posedge clock) begin
      step_beat_type b;
      if (reset) begin
         req.valid <= 1'b0;
         send_burst = 0;
      end else begin
         if (req.valid && req.ready) begin
            b.command       = req.command;
            b.velocity      = req.velocity;
            b.coupling_now  = req.coupling_now;
            b.coupling_next = req.coupling_next;
            b.lower_now     = req.lower_energy_now;
            b.lower_next    = req.lower_energy_next;
            b.upper_now     = req.upper_energy_now;
            b.upper_next    = req.upper_energy_next;
            expected_matrices.push_back(advance_density(b));
            if (b.command) resets_sent++;
         end
         if (req.valid && !req.ready) begin
            // hold the beat until taken
         end else if (send_burst > 0) begin
            send_burst--;
            req.valid <= 1'b0;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            send_burst = $urandom_range(0, 5);
            req.valid <= 1'b0;
         end else if (pending_beats.size() > 0) begin
            b = pending_beats.pop_front();
            req.valid             <= 1'b1;
            req.command           <= b.command;
            req.velocity          <= b.velocity;
            req.coupling_now      <= b.coupling_now;
            req.coupling_next     <= b.coupling_next;
            req.lower_energy_now  <= b.lower_now;
            req.lower_energy_next <= b.lower_next;
            req.upper_energy_now  <= b.upper_now;
            req.upper_energy_next <= b.upper_next;
         end else begin
            req.valid <= 1'b0;
         end
      end
   end

   // ---------------- result monitor ----------------
   always @(posedge clock) begin
      matrix_type exp_m;
      logic signed [31:0] got[8];
      string names[8];
      bit bad;
      names = '{"pop_lower_re", "pop_lower_im", "coher_up_re", "coher_up_im",
                "coher_down_re", "coher_down_im", "pop_upper_re", "pop_upper_im"};
      if (reset) begin
         rsp.ready <= 1'b0;
         take_burst = 0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            got = '{rsp.pop_lower_re, rsp.pop_lower_im, rsp.coher_up_re, rsp.coher_up_im,
                    rsp.coher_down_re, rsp.coher_down_im, rsp.pop_upper_re,
                    rsp.pop_upper_im};
            if (expected_matrices.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("tb: matrix beat with none expected");
            end else begin
               exp_m = expected_matrices.pop_front();
               matrices_checked++;
               bad = 1'b0;
               for (int k = 0; k < 8; k++) begin
                  if (got[k] !== exp_m.entry[k]) begin
                     bad = 1'b1;
                     if (mismatches < 10)
                        $display("tb: beat %0d %s expected %h got %h", matrices_checked,
                                 names[k], exp_m.entry[k], got[k]);
                  end
               end
               if (bad) mismatches++;
            end
         end
         if (take_burst > 0) begin
            take_burst--;
            rsp.ready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            take_burst = $urandom_range(0, 5);
            rsp.ready <= 1'b0;
         end else begin
            rsp.ready <= 1'b1;
         end
      end
   end

   // ---------------- stimulus ----------------
   function automatic logic signed [31:0] near_unity();
      return $signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
   endfunction

   function automatic step_beat_type random_beat();
      step_beat_type b;
      int pick;
      pick = $urandom_range(0, 99);
      b.command = (pick < 5);
      if (pick >= 5 && pick < 15) begin
         b.velocity      = $urandom;
         b.coupling_now  = $urandom;
         b.coupling_next = $urandom;
         b.lower_now     = $urandom;
         b.lower_next    = $urandom;
         b.upper_now     = $urandom;
         b.upper_next    = $urandom;
      end else begin
         b.velocity      = near_unity();
         b.coupling_now  = near_unity();
         b.coupling_next = near_unity();
         b.lower_now     = near_unity();
         b.lower_next    = near_unity();
         b.upper_now     = near_unity();
         b.upper_next    = near_unity();
      end
      return b;
   endfunction

   function automatic step_beat_type flat_beat(input logic cmd,
                                               input logic signed [31:0] x);
      step_beat_type b;
      b = '{cmd, x, x, x, x, x, x, x};
      return b;
   endfunction

   task automatic write_step_size(input logic [30:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {CSR_ADDR_W{1'b0}};
      pwdata  <= {1'b0, value};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      step_h = value;
   endtask

   // sample away from the rising edge so the driver and monitor have settled
   task automatic drain();
      do @(negedge clock);
      while (pending_beats.size() > 0 || expected_matrices.size() > 0 || req.valid);
      repeat (8) @(posedge clock);
   endtask

   task automatic queue_random(input int count);
      for (int i = 0; i < count; i++) pending_beats.push_back(random_beat());
   endtask

   initial begin
      step_beat_type b;
      reset = 1'b1;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      req.valid = 1'b0;
      req.command = 1'b0;
      req.velocity = '0;
      req.coupling_now = '0;
      req.coupling_next = '0;
      req.lower_energy_now = '0;
      req.lower_energy_next = '0;
      req.upper_energy_now = '0;
      req.upper_energy_next = '0;
      rsp.ready = 1'b0;
      quiet = 1'b0;
      mismatches = 0;
      matrices_checked = 0;
      resets_sent = 0;
      load_lower_state();
      step_h = longint'(STEP_RESET);
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: field extremes, reset command with junk fields, mixed signs
      pending_beats.push_back(flat_beat(1'b0, 32'sh0100_0000));
      pending_beats.push_back(flat_beat(1'b0, Q_MAX));
      pending_beats.push_back(flat_beat(1'b0, Q_MIN));
      pending_beats.push_back(flat_beat(1'b1, Q_MAX));
      pending_beats.push_back(flat_beat(1'b0, 32'sd0));
      b = '{1'b0, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MAX, Q_MIN};
      pending_beats.push_back(b);
      b = '{1'b0, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MIN, Q_MAX};
      pending_beats.push_back(b);
      pending_beats.push_back(flat_beat(1'b1, -32'sd1));
      b = '{1'b0, 32'sh0100_0000, 32'sh0080_0000, 32'sh0080_0001, -32'sd1, 32'sd0,
            32'sh0100_0000, 32'sh00ff_ffff};
      pending_beats.push_back(b);
      b = '{1'b0, -32'sh0100_0000, -32'sd3, 32'sd2, 32'sh0200_0000, -32'sh0200_0000,
            -32'sd1, 32'sd1};
      pending_beats.push_back(b);
      pending_beats.push_back(flat_beat(1'b0, -32'sd1));
      pending_beats.push_back(flat_beat(1'b1, 32'sd0));
      queue_random(250);
      drain();

      write_step_size(31'd0);
      pending_beats.push_back(flat_beat(1'b0, Q_MAX));
      queue_random(100);
      drain();

      write_step_size(31'h7fff_ffff);
      pending_beats.push_back(flat_beat(1'b0, Q_MIN));
      queue_random(100);
      drain();

      write_step_size(31'd1);
      queue_random(50);
      drain();

      write_step_size(31'd1 << 20);
      queue_random(550);
      drain();

      write_step_size(31'($urandom_range(1, 32'h0040_0000)));
      quiet = 1'b1;
      queue_random(450);
      drain();
      repeat (200) @(posedge clock);

      $display("tb: %0d matrix beats checked, %0d reset commands, six step sizes",
               matrices_checked, resets_sent);
      if (mismatches == 0 && expected_matrices.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: %0d mismatching beats", mismatches);
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("tb: timeout");
      $display("tb: failure");
      $finish;
   end

endmodule

`default_nettype wire
